// ----- rtl/core/mpds_pkg.sv -----
// Package for the multinode packet deframer with snapshot framing.
// Holds payload structs, parser entry type and framing constants.
// No dependencies.
package mpds_pkg;

	localparam logic [7:0] SYNC_IN  = 8'hAA;
	localparam logic [7:0] SYNC_A   = 8'hBB;
	localparam logic [7:0] SYNC_B   = 8'hCC;
	localparam logic [3:0] PKT_LAST = 4'd10;
	localparam logic [3:0] PHASE_LO = 4'd6;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_STREAM_EN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd1;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic       opcode;
		logic [2:0] node;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_byte;
	} out_item_t;

	// One node's parser state as it sits in the parser memory.
	typedef struct packed {
		logic [3:0]  count;
		logic [7:0]  xsum;
		logic [31:0] word;
	} parser_entry_t;

endpackage

// ----- rtl/core/multinode_packet_deframe_snapshot.sv -----
// Multinode packet deframer: per-node sync hunt, checksum check, snapshot framing.
// A memory-centered design: parser state and snapshot words sit in memories.
// Depends on mpds_pkg.
//
// Items: a word is accepted, read from the parser memory, updated and written back;
// in_stall holds off the next item until the parser memory write-back is done.
// A host frame of 9 + 4*NODES words follows the deciding item; header and checksum
// words go out one per cycle unless the output stalls; each node's word costs one
// snapshot memory read plus four bytes out. No items are taken while a frame drains.
// Reset clears all control state; memory entries read as zero until written.
module multinode_packet_deframe_snapshot
	import mpds_pkg::*;
#(
	parameter int NODES = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_item,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int NW  = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int NCW = $clog2(NODES + 1);
	localparam logic [3:0] NODES_L = 4'(NODES);
	localparam logic [NCW-1:0] NODES_C = NCW'(NODES);

	typedef enum logic [2:0] {
		S_IDLE, S_RD, S_UPD, S_HDR, S_FETCH, S_WORD, S_CSUM
	} state_t;

	state_t              state_q;
	in_item_t            item_s1;
	parser_entry_t       pmem [NODES];
	parser_entry_t       prd_s2;
	logic                pv_s2;
	logic [31:0]         smem [NODES];
	logic [31:0]         srd_q;
	logic                sv_rd_q;
	logic [NODES-1:0]    pv_q;
	logic [NODES-1:0]    sv_q;
	logic [NODES-1:0]    fresh_q;
	logic                en_q;
	logic [15:0]         tmo_q;
	logic [31:0]         ms_q;
	logic [31:0]         ws_q;
	logic [15:0]         seq_q;
	logic [2:0]          hk_q;
	logic [1:0]          lane_q;
	logic [NCW-1:0]      nj_q;
	logic [7:0]          cx_q;

	logic [3:0]          node_ext;
	logic [NW-1:0]       idx;
	logic                node_ok;
	logic                do_parse;
	parser_entry_t       ent;
	parser_entry_t       ent_nx;
	logic                good;
	logic [31:0]         ms_nx;
	logic [NODES-1:0]    fresh_nx;
	logic                fire;
	logic                slot_free;
	logic                emit;
	logic [7:0]          hdr_byte;
	logic [7:0]          word_byte;
	logic [31:0]         srd_word;

	assign in_stall  = (state_q != S_IDLE);
	assign slot_free = !out_valid || !out_stall;

	// A frame word is loaded whenever a frame state finds the output slot free.
	assign emit = slot_free &&
		(state_q == S_HDR || state_q == S_WORD || state_q == S_CSUM);

	// Decode the registered item.
	assign node_ext = {1'b0, item_s1.node};
	assign idx      = node_ext[NW-1:0];
	assign node_ok  = (node_ext < NODES_L);
	assign do_parse = (item_s1.opcode == OP_BYTE) && node_ok;
	assign ent      = pv_s2 ? prd_s2 : '0;

	// Parser step for one byte.
	always_comb begin
		ent_nx = ent;
		good   = 1'b0;
		if (ent.count == 4'd0) begin
			if (item_s1.data_byte == SYNC_IN) begin
				ent_nx.count = 4'd1;
				ent_nx.xsum  = SYNC_IN;
			end
		end else if (ent.count >= PKT_LAST) begin
			good         = (ent.xsum == item_s1.data_byte);
			ent_nx.count = 4'd0;
		end else begin
			ent_nx.xsum  = ent.xsum ^ item_s1.data_byte;
			ent_nx.count = ent.count + 4'd1;
			case (ent.count)
				PHASE_LO: ent_nx.word = {24'd0, item_s1.data_byte};
				4'd7:     ent_nx.word[15:8]  = item_s1.data_byte;
				4'd8:     ent_nx.word[23:16] = item_s1.data_byte;
				4'd9:     ent_nx.word[31:24] = item_s1.data_byte;
				default:  ent_nx.word = ent.word;
			endcase
		end
	end

	// Snapshot update and frame decision.
	always_comb begin
		ms_nx    = (item_s1.opcode == OP_TICK) ? ms_q + 32'd1 : ms_q;
		fresh_nx = fresh_q;
		if (do_parse && good && en_q)
			fresh_nx[idx] = 1'b1;
		fire = en_q && ((&fresh_nx) || ((ms_nx - ws_q) >= {16'd0, tmo_q}));
	end

	// Header byte select.
	always_comb begin
		case (hk_q)
			3'd0:    hdr_byte = SYNC_A;
			3'd1:    hdr_byte = SYNC_B;
			3'd2:    hdr_byte = seq_q[7:0];
			3'd3:    hdr_byte = seq_q[15:8];
			3'd4:    hdr_byte = ms_q[7:0];
			3'd5:    hdr_byte = ms_q[15:8];
			3'd6:    hdr_byte = ms_q[23:16];
			default: hdr_byte = ms_q[31:24];
		endcase
	end

	assign srd_word = sv_rd_q ? srd_q : 32'd0;

	always_comb begin
		case (lane_q)
			2'd0:    word_byte = srd_word[7:0];
			2'd1:    word_byte = srd_word[15:8];
			2'd2:    word_byte = srd_word[23:16];
			default: word_byte = srd_word[31:24];
		endcase
	end

	// Parser memory: read on the cycle after acceptance, written back in the update.
	always_ff @(posedge clk) begin
		if (state_q == S_RD)
			prd_s2 <= pmem[idx];
		if (state_q == S_UPD && do_parse)
			pmem[idx] <= ent_nx;
	end

	// Snapshot memory: written by good packets while streaming, read during a frame.
	always_ff @(posedge clk) begin
		if (state_q == S_UPD && do_parse && good && en_q)
			smem[idx] <= ent.word;
		if (state_q == S_FETCH)
			srd_q <= smem[nj_q[NW-1:0]];
	end

	// Item capture.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid)
			item_s1 <= in_item;
	end

	// Control, configuration and frame sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pv_q      <= '0;
			pv_s2     <= 1'b0;
			sv_q      <= '0;
			sv_rd_q   <= 1'b0;
			fresh_q   <= '0;
			en_q      <= 1'b0;
			tmo_q     <= 16'd100;
			ms_q      <= '0;
			ws_q      <= '0;
			seq_q     <= '0;
			hk_q      <= '0;
			lane_q    <= '0;
			nj_q      <= '0;
			cx_q      <= '0;
			out_valid <= 1'b0;
			out_item  <= '0;
		end else begin
			if (emit)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_STREAM_EN: begin
						if (cfg_data[0]) begin
							pv_q    <= '0;
							fresh_q <= '0;
							ws_q    <= ms_q;
							en_q    <= 1'b1;
						end else begin
							en_q    <= 1'b0;
						end
					end
					CFG_TIMEOUT: tmo_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_RD;
				end
				S_RD: begin
					pv_s2   <= node_ok && pv_q[idx];
					state_q <= S_UPD;
				end
				S_UPD: begin
					ms_q <= ms_nx;
					if (do_parse) begin
						pv_q[idx] <= 1'b1;
						if (good && en_q)
							sv_q[idx] <= 1'b1;
					end
					if (fire) begin
						fresh_q <= '0;
						ws_q    <= ms_nx;
						hk_q    <= '0;
						cx_q    <= '0;
						state_q <= S_HDR;
					end else begin
						fresh_q <= fresh_nx;
						state_q <= S_IDLE;
					end
				end
				S_HDR: begin
					if (slot_free) begin
						out_item  <= '{out_byte: hdr_byte, last_byte: 1'b0};
						cx_q      <= cx_q ^ hdr_byte;
						hk_q      <= hk_q + 3'd1;
						if (hk_q == 3'd7) begin
							nj_q    <= '0;
							state_q <= S_FETCH;
						end
					end
				end
				S_FETCH: begin
					sv_rd_q <= sv_q[nj_q[NW-1:0]];
					lane_q  <= '0;
					state_q <= S_WORD;
				end
				S_WORD: begin
					if (slot_free) begin
						out_item  <= '{out_byte: word_byte, last_byte: 1'b0};
						cx_q      <= cx_q ^ word_byte;
						lane_q    <= lane_q + 2'd1;
						if (lane_q == 2'd3) begin
							nj_q    <= nj_q + NCW'(1);
							state_q <= (nj_q + NCW'(1) == NODES_C) ? S_CSUM : S_FETCH;
						end
					end
				end
				S_CSUM: begin
					if (slot_free) begin
						out_item  <= '{out_byte: cx_q, last_byte: 1'b1};
						seq_q     <= seq_q + 16'd1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A full set of fresh marks always fires a frame, so it never survives to idle.
	a_fresh_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && en_q) |-> !(&fresh_q))
		else $error("all nodes fresh while idle");

	// The node counter stays inside the snapshot memory during a frame.
	a_fetch_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FETCH) |-> (nj_q < NODES_C))
		else $error("snapshot fetch beyond last node");

	// The checksum word ends the frame and returns the block to idle.
	a_csum_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CSUM && slot_free) |=> (state_q == S_IDLE && out_item.last_byte))
		else $error("frame did not end after checksum");

	// Fresh marks only appear while streaming.
	a_fresh_stream: assert property (@(posedge clk) disable iff (!arst_n)
		(!en_q && $stable(en_q)) |-> (fresh_q == $past(fresh_q) || fresh_q == '0))
		else $error("fresh mark set while stopped");

endmodule

// ----- sim/tb.sv -----
// Testbench for the multinode packet deframer with snapshot framing.
// Drives node bytes and millisecond ticks and predicts each host frame word.
// Depends on mpds_pkg and multinode_packet_deframe_snapshot.
`timescale 1ns / 100ps

module tb;
	import mpds_pkg::*;

	localparam int NUM_NODES = 8;
	localparam int FRAME_WORDS = 9 + 4 * NUM_NODES;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd2;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_item;
	logic out_valid;
	logic out_stall;
	out_item_t out_item;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Predicted state of the deframer.
	logic [3:0] pkt_count [NUM_NODES];
	logic [7:0] pkt_xsum [NUM_NODES];
	logic [31:0] pkt_word [NUM_NODES];
	logic [31:0] good_phase [NUM_NODES];
	bit phase_pending [NUM_NODES];
	logic [31:0] snap_phase [NUM_NODES];
	bit node_fresh [NUM_NODES];
	logic [31:0] ms_clock;
	logic [31:0] window_base;
	logic [15:0] frame_seq;
	bit streaming;
	logic [15:0] timeout_ms;

	out_item_t frame_words_due [$];
	logic [7:0] node_backlog [NUM_NODES][$];
	int errors;
	int items_sent;
	int frames_due;
	int words_checked;
	int burst_left;
	int cycles;

	multinode_packet_deframe_snapshot #(.NODES(NUM_NODES)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
	end

	// Clear every parser, as a stream enable write does.
	task automatic clear_parsers();
		for (int n = 0; n < NUM_NODES; n++) begin
			pkt_count[n] = '0;
			pkt_xsum[n] = '0;
			pkt_word[n] = '0;
			good_phase[n] = '0;
			phase_pending[n] = 1'b0;
		end
	endtask

	task automatic reset_prediction();
		clear_parsers();
		for (int n = 0; n < NUM_NODES; n++) begin
			snap_phase[n] = '0;
			node_fresh[n] = 1'b0;
		end
		ms_clock = '0;
		window_base = '0;
		frame_seq = '0;
		streaming = 1'b0;
		timeout_ms = 16'd100;
	endtask

	// Queue the host frame words built from the current snapshot.
	task automatic push_frame();
		logic [7:0] fb [FRAME_WORDS];
		logic [7:0] xsum;
		out_item_t w;
		xsum = '0;
		fb[0] = SYNC_A;
		fb[1] = SYNC_B;
		fb[2] = frame_seq[7:0];
		fb[3] = frame_seq[15:8];
		for (int k = 0; k < 4; k++)
			fb[4 + k] = ms_clock[8*k +: 8];
		for (int n = 0; n < NUM_NODES; n++)
			for (int k = 0; k < 4; k++)
				fb[8 + 4*n + k] = snap_phase[n][8*k +: 8];
		for (int i = 0; i < FRAME_WORDS - 1; i++)
			xsum ^= fb[i];
		fb[FRAME_WORDS-1] = xsum;
		for (int i = 0; i < FRAME_WORDS; i++) begin
			w.out_byte = fb[i];
			w.last_byte = (i == FRAME_WORDS - 1);
			frame_words_due.push_back(w);
		end
		frame_seq++;
		frames_due++;
	endtask

	// Advance the predicted state by one accepted word.
	task automatic predict_frames(input in_item_t it);
		int n;
		int c;
		bit all_fresh;
		n = it.node;
		c = pkt_count[n];
		all_fresh = 1'b1;
		if (it.opcode == OP_TICK) begin
			ms_clock++;
		end else if (c == 0) begin
			if (it.data_byte == SYNC_IN) begin
				pkt_count[n] = 4'd1;
				pkt_xsum[n] = SYNC_IN;
			end
		end else if (c >= PKT_LAST) begin
			if (pkt_xsum[n] == it.data_byte) begin
				good_phase[n] = pkt_word[n];
				phase_pending[n] = 1'b1;
			end
			pkt_count[n] = '0;
		end else begin
			pkt_xsum[n] ^= it.data_byte;
			if (c == PHASE_LO)
				pkt_word[n] = {24'd0, it.data_byte};
			else if (c > PHASE_LO)
				pkt_word[n] |= {24'd0, it.data_byte} << (8 * (c - PHASE_LO));
			pkt_count[n] = 4'(c + 1);
		end
		if (!streaming)
			return;
		for (int i = 0; i < NUM_NODES; i++) begin
			if (phase_pending[i]) begin
				snap_phase[i] = good_phase[i];
				node_fresh[i] = 1'b1;
				phase_pending[i] = 1'b0;
			end
			if (!node_fresh[i])
				all_fresh = 1'b0;
		end
		if (all_fresh || (ms_clock - window_base) >= {16'd0, timeout_ms}) begin
			push_frame();
			for (int i = 0; i < NUM_NODES; i++)
				node_fresh[i] = 1'b0;
			window_base = ms_clock;
		end
	endtask

	// Send one word; the sender runs in bursts with random gaps.
	task automatic send_word(input in_item_t it);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		in_item <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_frames(it);
		burst_left--;
		items_sent++;
	endtask

	task automatic send_byte(input int node, input logic [7:0] b);
		in_item_t it;
		it.opcode = OP_BYTE;
		it.node = node[2:0];
		it.data_byte = b;
		send_word(it);
	endtask

	task automatic send_tick();
		in_item_t it;
		it.opcode = OP_TICK;
		it.node = 3'($urandom);
		it.data_byte = 8'($urandom);
		send_word(it);
	endtask

	// Build an 11-byte packet for one node, with a good or broken checksum.
	task automatic queue_packet(input int node, input logic [31:0] phase, input bit corrupt);
		logic [7:0] p [11];
		logic [7:0] xsum;
		p[0] = SYNC_IN;
		for (int i = 1; i < 6; i++)
			p[i] = 8'($urandom);
		for (int k = 0; k < 4; k++)
			p[6 + k] = phase[8*k +: 8];
		xsum = '0;
		for (int i = 0; i < 10; i++)
			xsum ^= p[i];
		p[10] = corrupt ? xsum ^ 8'($urandom_range(1, 255)) : xsum;
		for (int i = 0; i < 11; i++)
			node_backlog[node].push_back(p[i]);
	endtask

	task automatic flush_backlog(input int node);
		while (node_backlog[node].size() > 0)
			send_byte(node, node_backlog[node].pop_front());
	endtask

	// Wait until the block has gone quiet so a register may be written.
	task automatic wait_idle();
		if (in_valid) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		burst_left = 0;
		while (frame_words_due.size() > 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_STREAM_EN) begin
			if (val[0]) begin
				clear_parsers();
				for (int n = 0; n < NUM_NODES; n++)
					node_fresh[n] = 1'b0;
				window_base = ms_clock;
				streaming = 1'b1;
			end else begin
				streaming = 1'b0;
			end
		end else if (idx == CFG_TIMEOUT) begin
			timeout_ms = val;
		end
	endtask

	// Parsers work while streaming is off; nothing may come out.
	task automatic test_parse_while_stopped();
		queue_packet(0, 32'h1234_5678, 1'b0);
		flush_backlog(0);
		send_tick();
		send_tick();
	endtask

	// Extreme phases, a broken checksum and a forced frame on timeout.
	task automatic test_extremes_and_timeout();
		write_reg(CFG_TIMEOUT, 16'd1);
		write_reg(CFG_STREAM_EN, 16'd1);
		queue_packet(7, 32'hFFFF_FFFF, 1'b0);
		flush_backlog(7);
		queue_packet(3, 32'h0000_0000, 1'b1);
		flush_backlog(3);
		send_byte(5, 8'h00);
		send_byte(5, 8'hFF);
		send_tick();
	endtask

	// A zero timeout forces a frame on every word; spare indexes are ignored.
	task automatic test_zero_timeout();
		write_reg(CFG_TIMEOUT, 16'd0);
		write_reg(CFG_SPARE, 16'hFFFF);
		write_reg(CFG_SPARE + 2'd1, 16'h0000);
		send_byte(1, SYNC_IN);
		send_tick();
		send_byte(2, 8'h55);
		write_reg(CFG_STREAM_EN, 16'd1);
		send_tick();
	endtask

	// Random mix of packets, noise and ticks on all nodes.
	task automatic test_random_traffic(input int count, input bit pause_midway);
		int r;
		int n;
		for (int i = 0; i < count; i++) begin
			if (pause_midway && i == count / 2) begin
				if (in_valid) begin
					in_valid <= 1'b0;
					@(posedge clk);
				end
				burst_left = 0;
				while (frame_words_due.size() > 0)
					@(posedge clk);
			end
			r = $urandom_range(0, 99);
			n = $urandom_range(0, NUM_NODES - 1);
			if (r < 12) begin
				send_tick();
			end else if (r < 20) begin
				send_byte(n, 8'($urandom));
			end else begin
				if (node_backlog[n].size() == 0)
					queue_packet(n, ($urandom_range(0, 9) == 0) ?
						{32{1'($urandom)}} : 32'($urandom),
						$urandom_range(0, 9) == 0);
				send_byte(n, node_backlog[n].pop_front());
			end
		end
	endtask

	// Check each accepted frame word against the oldest prediction.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (frame_words_due.size() == 0) begin
				$error("unexpected frame word %h", out_item);
				errors++;
			end else begin
				want = frame_words_due.pop_front();
				words_checked++;
				if (out_item.out_byte !== want.out_byte) begin
					$error("out_byte: expected %h, got %h", want.out_byte, out_item.out_byte);
					errors++;
				end
				if (out_item.last_byte !== want.last_byte) begin
					$error("last_byte: expected %b, got %b", want.last_byte,
						out_item.last_byte);
					errors++;
				end
			end
		end
	end

	// Receiver stalls in modes that change every so often.
	always @(posedge clk) begin
		int stall_mode;
		if (cycles % 64 == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 2) == 0);
			2: out_stall <= (cycles % 8) < 5;
			default: out_stall <= ($urandom_range(0, 9) == 0);
		endcase
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		errors = 0;
		items_sent = 0;
		frames_due = 0;
		words_checked = 0;
		burst_left = 0;
		cycles = 0;
		reset_prediction();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_parse_while_stopped();
		test_extremes_and_timeout();
		test_zero_timeout();
		write_reg(CFG_TIMEOUT, 16'd20);
		test_random_traffic(70, 1'b1);
		write_reg(CFG_TIMEOUT, 16'd1);
		test_random_traffic(30, 1'b0);
		write_reg(CFG_STREAM_EN, 16'd0);
		test_random_traffic(20, 1'b0);
		write_reg(CFG_TIMEOUT, 16'd65535);
		write_reg(CFG_STREAM_EN, 16'd1);
		test_random_traffic(100, 1'b0);

		wait_idle();
		repeat (50) @(posedge clk);
		$display("Sent %0d words (bytes and ticks); checked %0d frame words in %0d frames.",
			items_sent, words_checked, frames_due);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/mpds_pkg.sv
rtl/core/multinode_packet_deframe_snapshot.sv
sim/tb.sv
